// ===== design/mpr_pkg.sv =====
// Shared types and constants for the MED prediction residual block.
package mpr_pkg;

  localparam int unsigned MaxLineDef = 4096;
  localparam int unsigned PixW       = 8;
  localparam int unsigned ResW       = 9;
  localparam int unsigned LenW       = 13;
  localparam int unsigned StartW     = 12;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 13;

  localparam logic [LenW-1:0]   LineLengthRst = 13'd720;
  localparam logic [StartW-1:0] UStartRst     = 12'd480;
  localparam logic [StartW-1:0] VStartRst     = 12'd600;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LINE_LENGTH = 2'd0,
    REG_U_START     = 2'd1,
    REG_V_START     = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_e;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic [PixW-1:0] prev_pixel;
    logic            first_line;
    logic            plane_start;
    plane_e          plane;
    logic            line_end;
  } scan_ctx_t;

endpackage

// ===== design/mpr_pix_if.sv =====
// Pixel input channel: valid/ready with pixel and frame start mark.
interface mpr_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       frame_start;

  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

// ===== design/mpr_res_if.sv =====
// Result channel: valid/ready with residual, plane tag and line end flag.
interface mpr_res_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] residual;
  logic [1:0]        plane;
  logic              line_end;

  modport source (output valid, residual, plane, line_end, input ready);
  modport sink   (input valid, residual, plane, line_end, output ready);
endinterface

// ===== design/mpr_scan.sv =====
// Scan position tracking, config registers and previous-line buffer.
module mpr_scan #(
  parameter int unsigned MAX_LINE = mpr_pkg::MaxLineDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mpr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [mpr_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  input  logic [mpr_pkg::PixW-1:0]       in_pixel_i,
  input  logic                           in_frame_start_i,
  output logic                           in_ready_o,
  output logic                           ctx_valid_o,
  output mpr_pkg::scan_ctx_t             ctx_o,
  output logic [mpr_pkg::PixW-1:0]       upper_o,
  input  logic                           ctx_ready_i
);

  localparam int unsigned PW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam int unsigned CW = (PW + 1 > mpr_pkg::LenW) ? PW + 1 : mpr_pkg::LenW;
  localparam logic [CW-1:0] MaxLen = CW'(MAX_LINE);
  localparam logic [CW-1:0] MinLen = CW'(2);

  logic [mpr_pkg::LenW-1:0]   line_length_q;
  logic [mpr_pkg::StartW-1:0] u_start_q, v_start_q;
  logic [PW-1:0]              pos_q, pos_d, pos_eff;
  logic                       first_q, first_d, first_eff;
  logic [mpr_pkg::PixW-1:0]   prev_pixel_q;
  logic                       ctx_valid_q;
  mpr_pkg::scan_ctx_t         ctx_q, ctx_d;
  logic [mpr_pkg::PixW-1:0]   upper_q;
  logic [mpr_pkg::PixW-1:0]   mem [MAX_LINE];
  logic [CW-1:0]              len_raw, len_c, pos_ext, u_ext, v_ext;
  logic                       accept, last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q <= mpr_pkg::LineLengthRst;
      u_start_q     <= mpr_pkg::UStartRst;
      v_start_q     <= mpr_pkg::VStartRst;
    end else if (cfg_we_i) begin
      case (mpr_pkg::cfg_reg_e'(cfg_idx_i))
        mpr_pkg::REG_LINE_LENGTH: line_length_q <= cfg_data_i[mpr_pkg::LenW-1:0];
        mpr_pkg::REG_U_START:     u_start_q     <= cfg_data_i[mpr_pkg::StartW-1:0];
        mpr_pkg::REG_V_START:     v_start_q     <= cfg_data_i[mpr_pkg::StartW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !ctx_valid_q || ctx_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    pos_eff   = in_frame_start_i ? '0 : pos_q;
    first_eff = in_frame_start_i | first_q;
    len_raw   = CW'(line_length_q);
    if (len_raw < MinLen) begin
      len_c = MinLen;
    end else if (len_raw > MaxLen) begin
      len_c = MaxLen;
    end else begin
      len_c = len_raw;
    end
    pos_ext = CW'(pos_eff);
    u_ext   = CW'(u_start_q);
    v_ext   = CW'(v_start_q);
    last    = pos_ext >= len_c - CW'(1);
    pos_d   = last ? '0 : pos_eff + PW'(1);
    first_d = last ? 1'b0 : first_eff;

    ctx_d.pixel       = in_pixel_i;
    ctx_d.prev_pixel  = prev_pixel_q;
    ctx_d.first_line  = first_eff;
    ctx_d.plane_start = (pos_ext == '0) || (pos_ext == u_ext) || (pos_ext == v_ext);
    ctx_d.line_end    = last;
    if (pos_ext < u_ext) begin
      ctx_d.plane = mpr_pkg::PLANE_Y;
    end else if (pos_ext < v_ext) begin
      ctx_d.plane = mpr_pkg::PLANE_U;
    end else begin
      ctx_d.plane = mpr_pkg::PLANE_V;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      first_q      <= 1'b1;
      prev_pixel_q <= '0;
      ctx_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        pos_q        <= pos_d;
        first_q      <= first_d;
        prev_pixel_q <= in_pixel_i;
        ctx_valid_q  <= 1'b1;
      end else if (ctx_ready_i) begin
        ctx_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctx_q <= ctx_d;
    end
  end

  // read-before-write: the same position returns last line's sample
  always_ff @(posedge clk_i) begin
    if (accept) begin
      upper_q      <= mem[pos_eff];
      mem[pos_eff] <= in_pixel_i;
    end
  end

  assign ctx_valid_o = ctx_valid_q;
  assign ctx_o       = ctx_q;
  assign upper_o     = upper_q;

  a_line_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last |=> pos_q == '0 && !first_q)
    else $error("position did not wrap at line end");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !last |=> pos_q == $past(pos_eff) + PW'(1))
    else $error("position did not advance");

  a_frame_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_frame_start_i |=> ctx_q.first_line && ctx_q.plane_start)
    else $error("frame start not seen as first line at plane start");

endmodule

// ===== design/mpr_med.sv =====
// MED prediction, residual and output register.
module mpr_med (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     ctx_valid_i,
  input  mpr_pkg::scan_ctx_t       ctx_i,
  input  logic [mpr_pkg::PixW-1:0] upper_i,
  output logic                     ctx_ready_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [mpr_pkg::ResW-1:0] residual_o,
  output logic [1:0]               plane_o,
  output logic                     line_end_o
);

  logic [mpr_pkg::PixW-1:0] prev_upper_q;
  logic [mpr_pkg::PixW-1:0] a, b, c, lo, hi, pred;
  logic [mpr_pkg::PixW+1:0] grad;
  logic [mpr_pkg::ResW-1:0] res_d, res_q;
  logic                     out_valid_q, line_end_q, xfer;
  mpr_pkg::plane_e          plane_q;

  assign ctx_ready_o = !out_valid_q || out_ready_i;
  assign xfer        = ctx_valid_i && ctx_ready_o;

  always_comb begin
    a    = ctx_i.first_line ? '0 : upper_i;
    b    = ctx_i.plane_start ? '0 : ctx_i.prev_pixel;
    c    = (ctx_i.first_line || ctx_i.plane_start) ? '0 : prev_upper_q;
    lo   = (a < b) ? a : b;
    hi   = (a < b) ? b : a;
    grad = {2'b00, a} + {2'b00, b} - {2'b00, c};
    if (c >= hi) begin
      pred = lo;
    end else if (c <= lo) begin
      pred = hi;
    end else begin
      pred = grad[mpr_pkg::PixW-1:0];
    end
    res_d = {1'b0, ctx_i.pixel} - {1'b0, pred};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      prev_upper_q <= '0;
    end else begin
      if (xfer) begin
        out_valid_q  <= 1'b1;
        prev_upper_q <= upper_i;
      end else if (out_ready_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer) begin
      res_q      <= res_d;
      plane_q    <= ctx_i.plane;
      line_end_q <= ctx_i.line_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign residual_o  = res_q;
  assign plane_o     = plane_q;
  assign line_end_o  = line_end_q;

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer |=> out_valid_q)
    else $error("result lost after context transfer");

  a_first_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && ctx_i.first_line && ctx_i.plane_start |=> res_q == {1'b0, $past(ctx_i.pixel)})
    else $error("first-line plane start residual is not the pixel");

endmodule

// ===== design/med_prediction_residual_core.sv =====
// Top level of the MED prediction residual block.
//
// Pixels of a stacked Y/U/V 4:2:0 frame enter on pix_in, one per transfer,
// in line scan order; frame_start marks the first pixel of a frame. Each
// pixel yields one result on res_out: pixel minus the median edge detector
// prediction, its plane tag and a line end flag.
// One pixel is taken per clock into the mpr_scan context register and then the
// mpr_med result register, unless back-pressure fills both; the previous line lives
// in a single-port line buffer that is read and written once per pixel. Registers
// (line_length, u_start, v_start) are written over cfg_*; the user must write them
// only while no pixel is in flight, as the block does not enforce it. Reset restores
// the register defaults, clears the position and marks the next line as a first
// line; the line buffer is not cleared and is not used on a first line.
// When the receiver stalls, the result register holds and the stage in
// front of it fills; pix_in.ready drops only when both are occupied.
module med_prediction_residual_core #(
  parameter int unsigned MAX_LINE = mpr_pkg::MaxLineDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mpr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mpr_pkg::CfgDataW-1:0] cfg_data_i,
  mpr_pix_if.sink                      pix_in,
  mpr_res_if.source                    res_out
);

  logic                     ctx_valid, ctx_ready;
  mpr_pkg::scan_ctx_t       ctx;
  logic [mpr_pkg::PixW-1:0] upper;

  mpr_scan #(
    .MAX_LINE (MAX_LINE)
  ) u_scan (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (pix_in.valid),
    .in_pixel_i       (pix_in.pixel),
    .in_frame_start_i (pix_in.frame_start),
    .in_ready_o       (pix_in.ready),
    .ctx_valid_o      (ctx_valid),
    .ctx_o            (ctx),
    .upper_o          (upper),
    .ctx_ready_i      (ctx_ready)
  );

  mpr_med u_med (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctx_valid_i (ctx_valid),
    .ctx_i       (ctx),
    .upper_i     (upper),
    .ctx_ready_o (ctx_ready),
    .out_valid_o (res_out.valid),
    .out_ready_i (res_out.ready),
    .residual_o  (res_out.residual),
    .plane_o     (res_out.plane),
    .line_end_o  (res_out.line_end)
  );

endmodule

// ===== tb/sv/tb_med_prediction_residual_core.sv =====
// Testbench for med_prediction_residual_core: directed and random pixel streams checked against a MED predictor.
`timescale 1ns / 1ps

module tb_med_prediction_residual_core;

  typedef struct packed {
    logic [mpr_pkg::PixW-1:0] pixel;
    logic                     frame_start;
  } pix_item_t;

  typedef struct {
    logic signed [mpr_pkg::ResW-1:0] residual;
    mpr_pkg::plane_e                 plane;
    logic                            line_end;
  } res_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                         cfg_we   = 1'b0;
  mpr_pkg::cfg_reg_e            cfg_idx  = mpr_pkg::REG_LINE_LENGTH;
  logic [mpr_pkg::CfgDataW-1:0] cfg_data = '0;

  logic                     drv_valid = 1'b0;
  logic [mpr_pkg::PixW-1:0] drv_pixel = '0;
  logic                     drv_fs    = 1'b0;
  logic                     rx_ready  = 1'b0;

  mpr_pix_if pix_ch ();
  mpr_res_if res_ch ();

  assign pix_ch.valid       = drv_valid;
  assign pix_ch.pixel       = drv_pixel;
  assign pix_ch.frame_start = drv_fs;
  assign res_ch.ready       = rx_ready;

  med_prediction_residual_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_in     (pix_ch),
    .res_out    (res_ch)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // pixels waiting to be sent and residuals predicted for them
  pix_item_t pixel_q[$];
  res_item_t residual_q[$];

  int unsigned pixels_sent   = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned n_settings    = 0;
  int unsigned tx_gap        = 0;
  int unsigned rx_gap        = 0;
  int unsigned hold_reqs     = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  bit          calm          = 1'b0;
  int          gen_prev      = 0;

  // predictor state and register shadows
  logic [mpr_pkg::PixW-1:0]   line_mem [mpr_pkg::MaxLineDef];
  bit                         line_seen [mpr_pkg::MaxLineDef];
  logic [mpr_pkg::StartW-1:0] scan_pos = '0;
  bit                         first_ln = 1'b1;
  logic [mpr_pkg::PixW-1:0]   prev_px  = '0;
  logic [mpr_pkg::PixW-1:0]   prev_up  = '0;
  logic [mpr_pkg::LenW-1:0]   cfg_len  = mpr_pkg::LineLengthRst;
  logic [mpr_pkg::StartW-1:0] cfg_u    = mpr_pkg::UStartRst;
  logic [mpr_pkg::StartW-1:0] cfg_v    = mpr_pkg::VStartRst;

  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned eff_len();
    if (cfg_len < 2) return 2;
    if (cfg_len > mpr_pkg::MaxLineDef) return mpr_pkg::MaxLineDef;
    return 32'(cfg_len);
  endfunction

  function automatic logic [mpr_pkg::PixW-1:0] gen_pixel();
    int unsigned r;
    int          v;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      v = $urandom_range(0, 255);
    end else if (r < 8) begin
      v = gen_prev + int'($urandom_range(0, 16)) - 8;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
    end else begin
      v = (r == 8) ? 0 : 255;
    end
    gen_prev = v;
    return 8'(v);
  endfunction

  // Queue one pixel and the residual the block must give for it.
  function automatic void predict_med_residual(logic [mpr_pkg::PixW-1:0] px, logic fs_in);
    pix_item_t                item;
    res_item_t                r;
    int unsigned              eff;
    int                       a, b, c, lo, hi, pred;
    logic [mpr_pkg::PixW-1:0] upper;
    logic                     fs;
    bit                       pstart, last;
    fs  = fs_in;
    eff = eff_len();
    // never let a later line read a buffer entry that was not written
    if (!fs && !first_ln && !line_seen[scan_pos]) fs = 1'b1;
    if (fs) begin
      scan_pos = '0;
      first_ln = 1'b1;
    end
    upper  = line_mem[scan_pos];
    pstart = (scan_pos == 0) || (scan_pos == cfg_u) || (scan_pos == cfg_v);
    a = first_ln ? 0 : int'(upper);
    b = pstart ? 0 : int'(prev_px);
    c = (first_ln || pstart) ? 0 : int'(prev_up);
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c >= hi) pred = lo;
    else if (c <= lo) pred = hi;
    else pred = a + b - c;
    r.residual = 9'(int'(px) - pred);
    r.plane    = (scan_pos < cfg_u) ? mpr_pkg::PLANE_Y :
                 ((scan_pos < cfg_v) ? mpr_pkg::PLANE_U : mpr_pkg::PLANE_V);
    last       = (scan_pos >= eff - 1);
    r.line_end = last;
    line_mem[scan_pos]  = px;
    line_seen[scan_pos] = 1'b1;
    prev_px = px;
    prev_up = upper;
    if (last) begin
      scan_pos = '0;
      first_ln = 1'b0;
    end else begin
      scan_pos = scan_pos + 1'b1;
    end
    item.pixel       = px;
    item.frame_start = fs;
    pixel_q.insert(pixel_q.size(), item);
    residual_q.insert(residual_q.size(), r);
  endfunction

  always @(posedge clk_i) begin : drive_proc
    pix_item_t nxt;
    logic      nv;
    nv = drv_valid;
    if (drv_valid && pix_ch.ready) begin
      pixels_sent++;
      nv = 1'b0;
    end
    if (rst_ni && !nv) begin
      if (tx_gap != 0) begin
        tx_gap--;
      end else if (pixel_q.size() != 0) begin
        nxt = pixel_q.pop_front();
        drv_pixel <= nxt.pixel;
        drv_fs    <= nxt.frame_start;
        nv = 1'b1;
        tx_gap = pick_gap(calm);
      end
    end
    drv_valid <= nv;
  end

  // long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= 300;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin : check_proc
    res_item_t want;
    logic      nr;
    if (res_ch.valid && rx_ready) begin
      results_seen++;
      if (residual_q.size() == 0) begin
        $display("%0t: unexpected transfer: residual %0d plane %0d line_end %0b",
                 $time, res_ch.residual, res_ch.plane, res_ch.line_end);
        mismatches++;
      end else begin
        want = residual_q.pop_front();
        if (res_ch.residual !== want.residual) begin
          $display("%0t: residual mismatch: expected %0d actual %0d",
                   $time, want.residual, res_ch.residual);
          mismatches++;
        end
        if (res_ch.plane !== want.plane) begin
          $display("%0t: plane mismatch: expected %0d actual %0d",
                   $time, want.plane, res_ch.plane);
          mismatches++;
        end
        if (res_ch.line_end !== want.line_end) begin
          $display("%0t: line_end mismatch: expected %0b actual %0b",
                   $time, want.line_end, res_ch.line_end);
          mismatches++;
        end
      end
      rx_gap = pick_gap(calm);
    end
    if (!rst_ni || hold_left != 0) begin
      nr = 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap--;
      nr = 1'b0;
    end else begin
      nr = 1'b1;
    end
    rx_ready <= nr;
  end

  task automatic wait_drain();
    while (pixel_q.size() != 0 || drv_valid || residual_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [mpr_pkg::CfgDataW-1:0] len_d,
                            logic [mpr_pkg::CfgDataW-1:0] u_d,
                            logic [mpr_pkg::CfgDataW-1:0] v_d);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= mpr_pkg::REG_LINE_LENGTH;
    cfg_data <= len_d;
    @(posedge clk_i);
    cfg_idx  <= mpr_pkg::REG_U_START;
    cfg_data <= u_d;
    @(posedge clk_i);
    cfg_idx  <= mpr_pkg::REG_V_START;
    cfg_data <= v_d;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    cfg_len = len_d;
    cfg_u   = u_d[mpr_pkg::StartW-1:0];
    cfg_v   = v_d[mpr_pkg::StartW-1:0];
    n_settings++;
  endtask

  task automatic run_random_phase(int unsigned ph);
    int unsigned                eff, n_items, left, k, r;
    logic [mpr_pkg::LenW-1:0]   len_d;
    logic [mpr_pkg::StartW-1:0] u, v;
    logic                       fs;
    if (ph == 0) len_d = 13'd0;
    else if (ph == 1) len_d = 13'd1;
    else if ($urandom_range(0, 9) < 8) len_d = 13'($urandom_range(2, 24));
    else len_d = 13'($urandom_range(60, 160));
    eff = (len_d < 2) ? 2 : 32'(len_d);
    r = $urandom_range(0, 9);
    if (r < 6) begin
      u = 12'($urandom_range(1, eff - 1));
      v = 12'($urandom_range(32'(u), eff - 1));
    end else if (r == 6) begin
      u = '0;
      v = 12'($urandom_range(0, eff - 1));
    end else if (r == 7) begin
      // bounds swapped
      v = 12'($urandom_range(1, eff - 1));
      u = 12'($urandom_range(32'(v), eff));
    end else if (r == 8) begin
      u = 12'($urandom_range(eff, 4095));
      v = 12'($urandom_range(eff, 4095));
    end else begin
      u = 12'($urandom());
      v = 12'($urandom());
    end
    write_regs(len_d, {1'($urandom_range(0, 1)), u}, {1'($urandom_range(0, 1)), v});
    calm <= (ph % 3 == 2);
    n_items = (eff + 16 > 40) ? eff + 16 : 40;
    // sometimes carry on the previous frame without a restart
    left = ($urandom_range(0, 4) == 0) ? eff : 0;
    for (k = 0; k < n_items; k++) begin
      if (left == 0) begin
        fs = 1'b1;
        if ($urandom_range(0, 9) == 0) left = $urandom_range(1, 2 * eff);
        else left = eff * $urandom_range(1, 4);
      end else begin
        fs = ($urandom_range(0, 99) == 0);
      end
      predict_med_residual(gen_pixel(), fs);
      left--;
    end
    if (ph == 3) hold_reqs <= hold_reqs + 1;
    wait_drain();
  endtask

  initial begin : stim
    int unsigned              k, ph;
    logic [mpr_pkg::PixW-1:0] dir_px [22];
    dir_px = '{8'd255, 8'd0, 8'd40, 8'd200, 8'd60, 8'd10,
               8'd50, 8'd250, 8'd30, 8'd100, 8'd20, 8'd255,
               8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd128,
               8'd9, 8'd99, 8'd77, 8'd5};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset register values: full line crossing both plane starts
    predict_med_residual(8'd255, 1'b1);
    predict_med_residual(8'd0, 1'b0);
    for (k = 2; k < 725; k++) predict_med_residual(gen_pixel(), 1'b0);
    wait_drain();

    // short lines, hand-picked neighbours, restart mid-line
    write_regs(13'd6, 13'd2, 13'd4);
    for (k = 0; k < 22; k++) predict_med_residual(dir_px[k], (k == 0) || (k == 20));
    wait_drain();

    // shrink the line while the position is already past the new end
    write_regs(13'd40, 13'd10, 13'd20);
    for (k = 0; k < 25; k++) predict_med_residual(gen_pixel(), k == 0);
    wait_drain();
    write_regs(13'd10, 13'd10, 13'd20);
    for (k = 0; k < 25; k++) predict_med_residual(gen_pixel(), 1'b0);
    wait_drain();

    for (ph = 0; ph < 10; ph++) run_random_phase(ph);

    // length register above the maximum, bounds at the top
    calm <= 1'b0;
    write_regs(13'h1FFF, 13'h1FFF, 13'h0FFF);
    for (k = 0; k < 64; k++) predict_med_residual(gen_pixel(), k == 0);
    wait_drain();

    repeat (8) @(posedge clk_i);
    $display("Run: %0d pixel transfers, %0d results over %0d register settings,",
             pixels_sent, results_seen, n_settings);
    $display("  lengths clamped low and high, odd plane bounds, restarts, long stalls.");
    if (mismatches == 0 && residual_q.size() == 0) begin
      $display("med_prediction_residual_core verification clean");
    end else begin
      $display("med_prediction_residual_core verification failed");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Timeout with %0d results outstanding", residual_q.size());
    $display("med_prediction_residual_core verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mpr_pkg.sv
design/mpr_pix_if.sv
design/mpr_res_if.sv
design/mpr_scan.sv
design/mpr_med.sv
design/med_prediction_residual_core.sv
tb/sv/tb_med_prediction_residual_core.sv
